>>> rtl/wsg_pkg.sv
`timescale 1ns / 1ps
package wsg_pkg;

  localparam int WSG_POINTS = 100;

  localparam int DAC_W    = 16;
  localparam int PT_W     = 10;
  localparam int WAVE_W   = 2;
  localparam int MV_W     = 12;
  localparam int PERIOD_W = 17;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_WAVE      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MEAN      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD    = 2'd3;

  localparam logic [WAVE_W-1:0]   WAVE_RESET   = WAVE_SINE;
  localparam logic [MV_W-1:0]     AMP_RESET    = 12'd2500;
  localparam logic [MV_W-1:0]     MEAN_RESET   = 12'd2500;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd1000;

  localparam int FULL_MV = 5000;

  typedef struct packed {
    logic [WAVE_W-1:0] wave_select;
    logic [MV_W-1:0]   amplitude_mv;
    logic [MV_W-1:0]   mean_mv;
  } cfg_t;

  typedef struct packed {
    logic [DAC_W-1:0] dac_code;
    logic [PT_W-1:0]  point_number;
    logic             was_clamped;
  } result_t;

  // Q1.15 sine of point idx out of points, evaluated during elaboration only.
  function automatic logic signed [15:0] sine_q15(input int idx, input int points);
    longint unsigned q30;
    longint unsigned half_pi;
    longint unsigned dividend;
    longint unsigned divisor;
    longint unsigned rem;
    longint unsigned p;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned s15;
    logic signed [15:0] v;
    q30      = 64'd1073741824;
    half_pi  = 64'd1686629713;
    dividend = longint'(idx) << 32;
    divisor  = longint'(points);
    rem      = 0;
    p        = 0;
    for (int b = 42; b >= 0; b--) begin
      rem = (rem << 1) | ((dividend >> b) & 64'd1);
      if (rem >= divisor) begin
        rem = rem - divisor;
        p = p | (64'd1 << b);
      end
    end
    quad = (p >> 30) & 64'd3;
    r = p & (q30 - 64'd1);
    if (quad[0]) begin
      r = q30 - r;
    end
    x  = (r * half_pi) >> 30;
    x2 = (x * x) >> 30;
    t  = q30;
    t  = q30 - (((x2 * t) >> 30) / 110);
    t  = q30 - (((x2 * t) >> 30) / 72);
    t  = q30 - (((x2 * t) >> 30) / 42);
    t  = q30 - (((x2 * t) >> 30) / 20);
    t  = q30 - (((x2 * t) >> 30) / 6);
    s  = (x * t) >> 30;
    if (s > q30) begin
      s = q30;
    end
    s15 = (s + 64'd16384) >> 15;
    if (s15 > 64'd32767) begin
      s15 = 64'd32767;
    end
    v = 16'(s15);
    if (quad[1]) begin
      v = -v;
    end
    return v;
  endfunction

endpackage

>>> rtl/waveform_sample_generator_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Word
// tick      in         push / full                   restart
// result    out        pop / empty                   dac_code, point_number, was_clamped
// config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A tick is taken in every cycle while the two-entry point queue has room.
// Each emitted point passes through the back end as a pop, seven fixed steps and a
// push; quotients come from combinational reciprocal multiplication. The back end pops
// a new point only after pushing the last. A point reaches the result ports through
// the point queue, back-end states and result queue. If points outpace the back end
// or the result queue backs up, the point queue fills and full rises.
// Synchronous reset clears the countdown, point index and queues and presets the registers.
module waveform_sample_generator_top #(
  parameter int POINTS = wsg_pkg::WSG_POINTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         restart,
  output logic                         empty,
  input  logic                         pop,
  output logic [wsg_pkg::DAC_W-1:0]    dac_code,
  output logic [wsg_pkg::PT_W-1:0]     point_number,
  output logic                         was_clamped,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsg_pkg::ADDR_W-1:0]   paddr,
  input  logic [wsg_pkg::DATA_W-1:0]   pwdata,
  output logic [wsg_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  import wsg_pkg::*;

  localparam int IDX_W = $clog2(POINTS);
  localparam int RES_W = $bits(result_t);

  logic [WAVE_W-1:0]    wave_select;
  logic [MV_W-1:0]      amplitude_mv;
  logic [MV_W-1:0]      mean_mv;
  logic [PERIOD_W-1:0]  point_period;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_write;
  cfg_t                 cfg;

  logic                 mid_push;
  logic [IDX_W-1:0]     mid_in;
  logic                 mid_full;
  logic                 mid_pop;
  logic [IDX_W-1:0]     mid_out;
  logic                 mid_empty;
  logic                 out_push;
  logic                 out_full;
  result_t              out_in;
  result_t              out_word;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_select  <= WAVE_RESET;
      amplitude_mv <= AMP_RESET;
      mean_mv      <= MEAN_RESET;
      point_period <= PERIOD_RESET;
    end else if (reg_write) begin
      case (reg_idx)
        REG_WAVE:      wave_select  <= pwdata[WAVE_W-1:0];
        REG_AMPLITUDE: amplitude_mv <= pwdata[MV_W-1:0];
        REG_MEAN:      mean_mv      <= pwdata[MV_W-1:0];
        REG_PERIOD:    point_period <= pwdata[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WAVE:      prdata = DATA_W'(wave_select);
      REG_AMPLITUDE: prdata = DATA_W'(amplitude_mv);
      REG_MEAN:      prdata = DATA_W'(mean_mv);
      REG_PERIOD:    prdata = DATA_W'(point_period);
      default:       prdata = '0;
    endcase
  end

  assign cfg.wave_select  = wave_select;
  assign cfg.amplitude_mv = amplitude_mv;
  assign cfg.mean_mv      = mean_mv;

  wsg_front #(
    .POINTS(POINTS),
    .IDX_W (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .restart     (restart),
    .point_period(point_period),
    .mid_push    (mid_push),
    .mid_idx     (mid_in),
    .mid_full    (mid_full)
  );

  wsg_fifo #(
    .WIDTH(IDX_W),
    .DEPTH(2)
  ) u_point_q (
    .clk      (clk),
    .rst      (rst),
    .push     (mid_push),
    .push_data(mid_in),
    .full     (mid_full),
    .pop      (mid_pop),
    .pop_data (mid_out),
    .empty    (mid_empty)
  );

  wsg_back #(
    .POINTS(POINTS),
    .IDX_W (IDX_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mid_empty(mid_empty),
    .mid_idx  (mid_out),
    .mid_pop  (mid_pop),
    .out_full (out_full),
    .out_push (out_push),
    .out_data (out_in)
  );

  wsg_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_result_q (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .push_data(out_in),
    .full     (out_full),
    .pop      (pop),
    .pop_data (out_word),
    .empty    (empty)
  );

  assign dac_code     = out_word.dac_code;
  assign point_number = out_word.point_number;
  assign was_clamped  = out_word.was_clamped;

endmodule

>>> rtl/wsg_fifo.sv
`timescale 1ns / 1ps
module wsg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/wsg_front.sv
`timescale 1ns / 1ps
module wsg_front #(
  parameter int POINTS = 100,
  parameter int IDX_W  = 7
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             restart,
  input  logic [wsg_pkg::PERIOD_W-1:0]     point_period,
  output logic                             mid_push,
  output logic [IDX_W-1:0]                 mid_idx,
  input  logic                             mid_full
);

  import wsg_pkg::*;

  logic [PERIOD_W-1:0] tick_countdown;
  logic [IDX_W-1:0]    point_index;
  logic [PERIOD_W-1:0] cd_eff;
  logic [IDX_W-1:0]    idx_eff;
  logic                accept;

  assign full     = mid_full;
  assign accept   = push && !mid_full;
  assign cd_eff   = restart ? '0 : tick_countdown;
  assign idx_eff  = restart ? '0 : point_index;
  assign mid_push = accept && (cd_eff == '0);
  assign mid_idx  = idx_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_countdown <= '0;
      point_index    <= '0;
    end else if (accept) begin
      if (cd_eff != '0) begin
        tick_countdown <= cd_eff - 1'b1;
        point_index    <= idx_eff;
      end else begin
        point_index    <= (idx_eff == IDX_W'(POINTS - 1)) ? '0 : idx_eff + 1'b1;
        tick_countdown <= (point_period == '0) ? '0 : point_period - 1'b1;
      end
    end
  end

endmodule

>>> rtl/wsg_div.sv
`timescale 1ns / 1ps
module wsg_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR    = 3
) (
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic [DIVIDEND_W-1:0] quotient
);

  // Floor division by a constant through the rounded-up reciprocal. The error
  // term stays below one for every dividend that fits in DIVIDEND_W bits.
  localparam int SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
  localparam int RECIP_W = DIVIDEND_W + 2;
  localparam int PROD_W  = DIVIDEND_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);

  logic [PROD_W-1:0] product;

  assign product  = PROD_W'(dividend) * PROD_W'(RECIP);
  assign quotient = DIVIDEND_W'(product >> SHIFT);

endmodule

>>> rtl/wsg_back.sv
`timescale 1ns / 1ps
module wsg_back #(
  parameter int POINTS = 100,
  parameter int IDX_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wsg_pkg::cfg_t         cfg,
  input  logic                  mid_empty,
  input  logic [IDX_W-1:0]      mid_idx,
  output logic                  mid_pop,
  input  logic                  out_full,
  output logic                  out_push,
  output wsg_pkg::result_t      out_data
);

  import wsg_pkg::*;

  localparam int H         = (POINTS / 2 > 0) ? POINTS / 2 : 1;
  localparam int SAW_DEN   = (POINTS - 1 > 0) ? POINTS - 1 : 1;
  localparam int NUM_W     = 31;
  localparam int QUO_W     = 24;
  localparam int MUL_W     = 17;
  localparam int V_W       = 13;
  localparam int Q_SH      = 15;
  localparam int SCALE_W   = 26;
  localparam int SCALE_MUL = ((1 << DAC_W) - 1) / 5;
  localparam int SCALE_DIV = FULL_MV / 5;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ROM    = 4'd1;
  localparam logic [3:0] ST_MUL_P  = 4'd2;
  localparam logic [3:0] ST_MUL_B  = 4'd3;
  localparam logic [3:0] ST_SUM    = 4'd4;
  localparam logic [3:0] ST_QUO    = 4'd5;
  localparam logic [3:0] ST_SCALE  = 4'd6;
  localparam logic [3:0] ST_CODE   = 4'd7;
  localparam logic [3:0] ST_PUSH   = 4'd8;

  logic signed [15:0]        sine_rom [POINTS];
  logic [3:0]                state;
  logic [IDX_W-1:0]          idx;
  logic signed [15:0]        sine_q;
  logic signed [NUM_W-1:0]   prod;
  logic signed [NUM_W-1:0]   base;
  logic signed [NUM_W-1:0]   total;
  logic [V_W-1:0]            mv;
  logic                      clamped;
  logic [SCALE_W-1:0]        scaled;
  logic [DAC_W-1:0]          code;

  logic signed [V_W-1:0]     amp_s;
  logic signed [V_W-1:0]     mean_s;
  logic signed [MUL_W-1:0]   idx_s;
  logic signed [MUL_W-1:0]   h_s;
  logic                      lower;
  logic signed [MUL_W-1:0]   s_term;
  logic signed [V_W:0]       bval;
  logic signed [MUL_W-1:0]   bmul;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          quo;
  logic [QUO_W-1:0]          tri_quo;
  logic [QUO_W-1:0]          saw_quo;
  logic [SCALE_W-1:0]        code_quo;

  for (genvar g = 0; g < POINTS; g++) begin : g_sine
    assign sine_rom[g] = sine_q15(g, POINTS);
  end

  assign amp_s  = signed'({1'b0, cfg.amplitude_mv});
  assign mean_s = signed'({1'b0, cfg.mean_mv});
  assign idx_s  = signed'(MUL_W'(idx));
  assign h_s    = signed'(MUL_W'(H));
  assign lower  = (idx < IDX_W'(H));

  always_comb begin
    case (cfg.wave_select)
      WAVE_SINE: begin
        s_term  = MUL_W'(sine_q);
        bval    = (V_W + 1)'(mean_s);
        bmul    = MUL_W'(32768);
      end
      WAVE_SQUARE: begin
        s_term  = lower ? MUL_W'(1) : -MUL_W'(1);
        bval    = (V_W + 1)'(mean_s);
        bmul    = MUL_W'(1);
      end
      WAVE_TRIANGLE: begin
        s_term  = lower ? (idx_s <<< 1) : -((idx_s - h_s) <<< 1);
        bval    = lower ? ((V_W + 1)'(mean_s) - (V_W + 1)'(amp_s))
                        : ((V_W + 1)'(mean_s) + (V_W + 1)'(amp_s));
        bmul    = MUL_W'(H);
      end
      default: begin
        // Sawtooth.
        s_term  = idx_s <<< 1;
        bval    = (V_W + 1)'(mean_s) - (V_W + 1)'(amp_s);
        bmul    = MUL_W'(SAW_DEN);
      end
    endcase
  end

  always_comb begin
    if (state == ST_MUL_P) begin
      mul_a = MUL_W'(amp_s);
      mul_b = s_term;
    end else begin
      mul_a = MUL_W'(bval);
      mul_b = bmul;
    end
  end

  assign mul_p = mul_a * mul_b;
  assign num   = base + prod;

  always_comb begin
    case (cfg.wave_select)
      WAVE_SINE:     quo = NUM_W'(total[NUM_W-1:Q_SH]);
      WAVE_SQUARE:   quo = total;
      WAVE_TRIANGLE: quo = NUM_W'(tri_quo);
      default:       quo = NUM_W'(saw_quo);
    endcase
  end

  wsg_div #(
    .DIVIDEND_W(QUO_W),
    .DIVISOR   (H)
  ) u_div_tri (
    .dividend(total[QUO_W-1:0]),
    .quotient(tri_quo)
  );

  wsg_div #(
    .DIVIDEND_W(QUO_W),
    .DIVISOR   (SAW_DEN)
  ) u_div_saw (
    .dividend(total[QUO_W-1:0]),
    .quotient(saw_quo)
  );

  wsg_div #(
    .DIVIDEND_W(SCALE_W),
    .DIVISOR   (SCALE_DIV)
  ) u_div_code (
    .dividend(scaled),
    .quotient(code_quo)
  );

  assign mid_pop  = (state == ST_IDLE) && !mid_empty;
  assign out_push = (state == ST_PUSH) && !out_full;

  assign out_data.dac_code     = code;
  assign out_data.point_number = PT_W'(idx);
  assign out_data.was_clamped  = clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!mid_empty) begin
            state <= ST_ROM;
          end
        end
        ST_ROM: begin
          state <= ST_MUL_P;
        end
        ST_MUL_P: begin
          state <= ST_MUL_B;
        end
        ST_MUL_B: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_QUO;
        end
        ST_QUO: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_CODE;
        end
        ST_CODE: begin
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!out_full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!mid_empty) begin
          idx <= mid_idx;
        end
      end
      ST_ROM: begin
        sine_q <= sine_rom[idx];
      end
      ST_MUL_P: begin
        prod <= NUM_W'(mul_p);
      end
      ST_MUL_B: begin
        base <= NUM_W'(mul_p);
      end
      ST_SUM: begin
        total <= num;
      end
      ST_QUO: begin
        if (total[NUM_W-1]) begin
          mv      <= '0;
          clamped <= 1'b1;
        end else if (quo > NUM_W'(FULL_MV)) begin
          mv      <= V_W'(FULL_MV);
          clamped <= 1'b1;
        end else begin
          mv      <= V_W'(quo);
          clamped <= 1'b0;
        end
      end
      ST_SCALE: begin
        scaled <= SCALE_W'(mv) * SCALE_W'(SCALE_MUL);
      end
      ST_CODE: begin
        code <= DAC_W'(code_quo);
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_mv_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE) |-> (mv <= V_W'(FULL_MV)))
    else $error("millivolt value above full scale");

  a_clamp_edge: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE && clamped) |-> (mv == '0 || mv == V_W'(FULL_MV)))
    else $error("clamped value is not at a rail");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> (state == ST_IDLE))
    else $error("point queue popped outside the idle state");

  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    (state <= ST_PUSH))
    else $error("state register holds an unused code");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH && mv == '0) |-> (code == '0))
    else $error("zero millivolts gave a nonzero code");
`endif

endmodule
